[src/gpsnsw_pkg.sv]
// ----------------------------------------------------------------------------
// GPS navigation subframe word conditioner package
// Shared constants and the word parity function for the subframe conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package gpsnsw_pkg;

  localparam int WORD_W      = 30;
  localparam int DATA_W      = 24;
  localparam int PAR_W       = 6;
  localparam int INDEX_W     = 4;
  localparam int TOW_COUNT_W = 17;
  localparam int TOW_W       = 20;
  localparam int SFID_W      = 3;
  localparam int SVID_W      = 6;
  localparam int PRE_W       = 8;

  localparam logic [INDEX_W-1:0] WORDS_PER_SUBFRAME = 4'd10;
  localparam logic [INDEX_W-1:0] IDX_FIRST          = 4'd1;
  localparam logic [INDEX_W-1:0] IDX_HOW            = 4'd2;
  localparam logic [INDEX_W-1:0] IDX_PAGE           = 4'd3;

  localparam logic [PRE_W-1:0]  PRE_INVERTED = 8'h74;
  localparam logic [PRE_W-1:0]  PRE_UPRIGHT  = 8'h8b;
  localparam logic [SFID_W-1:0] SFID_PAGED   = 3'd4;

  // Data bit masks for parity bits D25 to D30; bit 23 of a mask is D1.
  localparam logic [DATA_W-1:0] PAR_MASK [PAR_W] = '{
    24'hEC7CD2, 24'h763E69, 24'hBB1F34, 24'h5D8F9A, 24'hAEC7CD, 24'h2DEA27
  };

  // Set where the equation is seeded by the previous D30, clear for D29.
  localparam logic [PAR_W-1:0] PAR_SEED_D30 = 6'b010110;

  typedef logic [WORD_W-1:0] word_t;

  function automatic logic [PAR_W-1:0] calc_parity(
    input logic [DATA_W-1:0] data,
    input logic              p29,
    input logic              p30
  );
    logic [PAR_W-1:0] res;
    res = '0;
    for (int k = 0; k < PAR_W; k++) begin
      res[PAR_W-1-k] = ^(data & PAR_MASK[k]) ^ (PAR_SEED_D30[PAR_W-1-k] ? p30 : p29);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[src/gps_nav_subframe_word_conditioner.sv]
// ----------------------------------------------------------------------------
// GPS navigation subframe word conditioner
// Polarity resolution, D30 data correction, parity check, HOW field extraction
// and page SV ID extraction for the ten words of a navigation subframe.
// ----------------------------------------------------------------------------
// Each accepted word yields exactly one result word in the next cycle. The
// block takes one word per cycle: the whole correction and parity check is a
// single level of logic from the input port into the result register, and the
// input is ready whenever the result register is empty or being drained.
// Word 1 of a subframe is marked by start_req, or implied when no subframe is
// open or the previous subframe has completed ten words.
`default_nettype none

module gps_nav_subframe_word_conditioner (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [gpsnsw_pkg::WORD_W-1:0]         nav_word,
  input  wire logic                                  start_req,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [gpsnsw_pkg::WORD_W-1:0]              corrected_word,
  output logic [gpsnsw_pkg::INDEX_W-1:0]             word_index,
  output logic                                       was_inverted,
  output logic                                       is_upright,
  output logic                                       word_parity_ok,
  output logic                                       subframe_parity_ok,
  output logic [gpsnsw_pkg::TOW_W-1:0]               time_of_week,
  output logic [gpsnsw_pkg::SFID_W-1:0]              subframe_id,
  output logic [gpsnsw_pkg::SVID_W-1:0]              page_sv_id,
  output logic                                       last
);

  logic [gpsnsw_pkg::INDEX_W-1:0] word_count;
  logic                           invert_flag;
  logic                           upright_flag;
  logic                           prev_d29;
  logic                           prev_d30;
  logic                           parity_all_ok;
  logic [gpsnsw_pkg::TOW_W-1:0]   tow_hold;
  logic [gpsnsw_pkg::SFID_W-1:0]  sfid_hold;
  logic [gpsnsw_pkg::SVID_W-1:0]  svid_hold;

  logic [gpsnsw_pkg::INDEX_W-1:0]     idx_next;
  logic                               first_word;
  logic                               invert_next;
  logic                               upright_next;
  logic                               p29;
  logic                               p30;
  gpsnsw_pkg::word_t                  w;
  gpsnsw_pkg::word_t                  pdata;
  gpsnsw_pkg::word_t                  corr_next;
  logic                               ok_next;
  logic                               all_ok_next;
  logic [gpsnsw_pkg::TOW_COUNT_W-1:0] tow_count;
  logic [gpsnsw_pkg::TOW_W-1:0]       tow_next;
  logic [gpsnsw_pkg::SFID_W-1:0]      sfid_next;
  logic [gpsnsw_pkg::SVID_W-1:0]      svid_next;
  logic                               accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    first_word = start_req || (word_count == '0) ||
                 (word_count >= gpsnsw_pkg::WORDS_PER_SUBFRAME);
    idx_next   = first_word ? gpsnsw_pkg::IDX_FIRST : word_count + 4'd1;

    if (first_word) begin
      invert_next  = (nav_word[29:22] == gpsnsw_pkg::PRE_INVERTED);
      upright_next = ((invert_next ? ~nav_word[29:22] : nav_word[29:22]) ==
                      gpsnsw_pkg::PRE_UPRIGHT);
      p29          = 1'b0;
      p30          = 1'b0;
    end else begin
      invert_next  = invert_flag;
      upright_next = upright_flag;
      p29          = prev_d29;
      p30          = prev_d30;
    end

    w         = invert_next ? ~nav_word : nav_word;
    pdata     = {w[29:6] ^ {gpsnsw_pkg::DATA_W{p30}}, w[5:0]};
    corr_next = upright_next ? pdata : w;
    ok_next   = (gpsnsw_pkg::calc_parity(pdata[29:6], p29, p30) == w[5:0]);
    all_ok_next = first_word ? ok_next : (parity_all_ok && ok_next);

    tow_count = corr_next[29:13];
    if (first_word) begin
      tow_next  = '0;
      sfid_next = '0;
      svid_next = '0;
    end else if (idx_next == gpsnsw_pkg::IDX_HOW) begin
      tow_next  = {1'b0, tow_count, 2'b00} + {2'b00, tow_count, 1'b0};
      sfid_next = corr_next[10:8];
      svid_next = svid_hold;
    end else if (idx_next == gpsnsw_pkg::IDX_PAGE) begin
      tow_next  = tow_hold;
      sfid_next = sfid_hold;
      svid_next = (sfid_hold >= gpsnsw_pkg::SFID_PAGED) ? corr_next[27:22] : '0;
    end else begin
      tow_next  = tow_hold;
      sfid_next = sfid_hold;
      svid_next = svid_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count    <= '0;
      invert_flag   <= 1'b0;
      upright_flag  <= 1'b0;
      prev_d29      <= 1'b0;
      prev_d30      <= 1'b0;
      parity_all_ok <= 1'b1;
      tow_hold      <= '0;
      sfid_hold     <= '0;
      svid_hold     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        word_count    <= idx_next;
        invert_flag   <= invert_next;
        upright_flag  <= upright_next;
        prev_d29      <= w[1];
        prev_d30      <= w[0];
        parity_all_ok <= all_ok_next;
        tow_hold      <= tow_next;
        sfid_hold     <= sfid_next;
        svid_hold     <= svid_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corrected_word     <= corr_next;
      word_index         <= idx_next;
      was_inverted       <= invert_next;
      is_upright         <= upright_next;
      word_parity_ok     <= ok_next;
      subframe_parity_ok <= all_ok_next;
      time_of_week       <= tow_next;
      subframe_id        <= sfid_next;
      page_sv_id         <= svid_next;
      last               <= (idx_next == gpsnsw_pkg::WORDS_PER_SUBFRAME);
    end
  end

endmodule

`default_nettype wire
